// ----- src/i2cdbw_pkg.sv -----
`default_nettype none
package i2cdbw_pkg;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START_SDA,
    PH_START_SCL,
    PH_BIT_SET,
    PH_BIT_HIGH,
    PH_BIT_LOW,
    PH_ACK_REL,
    PH_ACK_CLK,
    PH_ACK_POLL,
    PH_STOP_SDA,
    PH_STOP_SCL,
    PH_STOP_END
  } phase_t;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_DATA  = 2'd2;

  localparam logic REG_DEVICE_ADDRESS = 1'b0;
  localparam logic REG_ACK_TIMEOUT    = 1'b1;

  localparam logic [7:0] CTRL_CMD  = 8'h00;
  localparam logic [7:0] CTRL_DATA = 8'h40;

  localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'h78;
  localparam logic [7:0] ACK_TIMEOUT_RESET    = 8'd200;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned BYTES_PER_WRITE = 3;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] payload;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic scl_level;
    logic sda_level;
    logic busy_res;
    logic done_res;
    logic nack_seen;
  } result_t;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] bit_index;
    logic [1:0] byte_index;
    logic [7:0] shift_byte;
    logic [7:0] held_payload;
    logic       is_data_write;
    logic [7:0] poll_count;
    logic       nack_flag;
    logic       scl;
    logic       sda;
  } bus_state_t;

endpackage
`default_nettype wire

// ----- src/i2cdbw_step.sv -----
`default_nettype none
module i2cdbw_step (
  input  i2cdbw_pkg::bus_state_t st,
  input  i2cdbw_pkg::item_t      item,
  input  logic [7:0]             device_address_byte,
  input  logic [7:0]             ack_timeout_ticks,
  output i2cdbw_pkg::bus_state_t st_next,
  output i2cdbw_pkg::result_t    result_next
);
  import i2cdbw_pkg::*;

  logic       begin_write;
  logic [7:0] poll_inc;
  logic [7:0] poll_limit;
  logic       poll_timeout;
  logic       byte_end;
  logic [1:0] byte_inc;
  logic       last_byte;
  logic       last_bit;
  phase_t     phase_next;
  logic       done;

  assign begin_write  = (item.command == CMD_WRITE) || (item.command == CMD_DATA);
  assign poll_inc     = st.poll_count + 8'd1;
  assign poll_limit   = (ack_timeout_ticks == 8'd0) ? 8'd1 : ack_timeout_ticks;
  assign poll_timeout = (poll_inc >= poll_limit) || (poll_inc == 8'd0);
  assign byte_end     = (st.phase == PH_ACK_POLL) && (!item.sda_in || poll_timeout);
  assign byte_inc     = st.byte_index + 2'd1;
  assign last_byte    = (byte_inc >= 2'(BYTES_PER_WRITE));
  assign last_bit     = (st.bit_index >= 3'(BITS_PER_BYTE - 1));

  always_comb begin
    phase_next = st.phase;
    unique case (st.phase)
      PH_IDLE:      if (begin_write) phase_next = PH_START_SDA;
      PH_START_SDA: phase_next = PH_START_SCL;
      PH_START_SCL: phase_next = PH_BIT_SET;
      PH_BIT_SET:   phase_next = PH_BIT_HIGH;
      PH_BIT_HIGH:  phase_next = PH_BIT_LOW;
      PH_BIT_LOW:   phase_next = last_bit ? PH_ACK_REL : PH_BIT_SET;
      PH_ACK_REL:   phase_next = PH_ACK_CLK;
      PH_ACK_CLK:   phase_next = PH_ACK_POLL;
      PH_ACK_POLL: begin
        if (byte_end) phase_next = last_byte ? PH_STOP_SDA : PH_BIT_SET;
      end
      PH_STOP_SDA:  phase_next = PH_STOP_SCL;
      PH_STOP_SCL:  phase_next = PH_STOP_END;
      PH_STOP_END:  phase_next = PH_IDLE;
      default:      phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    st_next = st;
    done    = 1'b0;
    unique case (st.phase)
      PH_IDLE: begin
        if (begin_write) begin
          st_next.held_payload  = item.payload;
          st_next.is_data_write = (item.command == CMD_DATA);
          st_next.nack_flag     = 1'b0;
          st_next.byte_index    = '0;
          st_next.bit_index     = '0;
          st_next.poll_count    = '0;
          st_next.shift_byte    = device_address_byte;
          st_next.scl           = 1'b1;
          st_next.sda           = 1'b1;
        end
      end
      PH_START_SDA: begin
        st_next.scl = 1'b1;
        st_next.sda = 1'b0;
      end
      PH_START_SCL: begin
        st_next.scl = 1'b0;
        st_next.sda = 1'b0;
      end
      PH_BIT_SET: begin
        st_next.scl        = 1'b0;
        st_next.sda        = st.shift_byte[7];
        st_next.shift_byte = {st.shift_byte[6:0], 1'b0};
      end
      PH_BIT_HIGH: st_next.scl = 1'b1;
      PH_BIT_LOW: begin
        st_next.scl       = 1'b0;
        st_next.bit_index = last_bit ? 3'd0 : st.bit_index + 3'd1;
      end
      PH_ACK_REL: begin
        st_next.scl        = 1'b0;
        st_next.sda        = 1'b1;
        st_next.poll_count = '0;
      end
      PH_ACK_CLK: begin
        st_next.scl = 1'b1;
        st_next.sda = 1'b1;
      end
      PH_ACK_POLL: begin
        if (item.sda_in) begin
          st_next.poll_count = poll_inc;
          if (poll_timeout) st_next.nack_flag = 1'b1;
        end
        if (byte_end) begin
          st_next.scl        = 1'b0;
          st_next.byte_index = byte_inc;
          st_next.bit_index  = '0;
          if (!last_byte) begin
            st_next.shift_byte = (byte_inc == 2'd1)
                                 ? (st.is_data_write ? CTRL_DATA : CTRL_CMD)
                                 : st.held_payload;
          end
        end
      end
      PH_STOP_SDA: begin
        st_next.scl = 1'b0;
        st_next.sda = 1'b0;
      end
      PH_STOP_SCL: begin
        st_next.scl = 1'b1;
        st_next.sda = 1'b0;
      end
      PH_STOP_END: begin
        st_next.scl = 1'b1;
        st_next.sda = 1'b1;
        done        = 1'b1;
      end
      default: ;
    endcase
    st_next.phase = phase_next;
  end

  assign result_next = '{
    scl_level: st_next.scl,
    sda_level: st_next.sda,
    busy_res:  (phase_next != PH_IDLE),
    done_res:  done,
    nack_seen: st_next.nack_flag
  };

endmodule
`default_nettype wire

// ----- src/i2c_display_byte_writer_core.sv -----
// Bit-level I2C master that writes one byte to a display controller.
// Every beat on the item channel is one bus timing tick. A command of one
// or two while idle starts a command or data write of the payload byte;
// other beats just advance the bus sequence and supply the sampled SDA.
// Each accepted item yields exactly one beat on the result channel, which
// carries the SCL and SDA levels to drive, busy, done and the sticky
// missed-acknowledge flag of the current or last write.
// The result is registered and turns valid in the cycle after the item
// is accepted; one item is accepted every cycle unless stalled. The whole
// tick update is one pass of logic between the bus state registers and
// the result register. The item channel stalls only while a result is
// held and the receiver stalls it; no tick is lost or repeated.
// Configuration writes on wr_en/wr_index/wr_data set the device address
// byte (index 0) and the acknowledge timeout in ticks (index 1), and are
// meant for idle periods only.
// Synchronous reset returns the block to idle with both lines high, the
// address byte at 0x78 and the timeout at 200 ticks.
`default_nettype none
module i2c_display_byte_writer_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  i2cdbw_pkg::item_t   item,
  output logic                result_valid,
  input  logic                result_stall,
  output i2cdbw_pkg::result_t result,
  input  logic                wr_en,
  input  logic                wr_index,
  input  logic [7:0]          wr_data
);
  import i2cdbw_pkg::*;

  bus_state_t st;
  bus_state_t st_next;
  result_t    result_next;
  logic [7:0] device_address_byte;
  logic [7:0] ack_timeout_ticks;
  logic       accept;

  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  i2cdbw_step u_step (
    .st                  (st),
    .item                (item),
    .device_address_byte (device_address_byte),
    .ack_timeout_ticks   (ack_timeout_ticks),
    .st_next             (st_next),
    .result_next         (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address_byte <= DEVICE_ADDRESS_RESET;
      ack_timeout_ticks   <= ACK_TIMEOUT_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DEVICE_ADDRESS: device_address_byte <= wr_data;
        REG_ACK_TIMEOUT:    ack_timeout_ticks   <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{
        phase:         PH_IDLE,
        bit_index:     '0,
        byte_index:    '0,
        shift_byte:    '0,
        held_payload:  '0,
        is_data_write: 1'b0,
        poll_count:    '0,
        nack_flag:     1'b0,
        scl:           1'b1,
        sda:           1'b1
      };
      result_valid <= 1'b0;
    end else if (accept) begin
      st           <= st_next;
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

import i2cdbw_pkg::*;

class i2c_line_scoreboard;
  result_t    expected_levels[$];
  int         mismatches;
  logic [7:0] addr_byte;
  logic [7:0] timeout_ticks;
  phase_t     phase;
  logic [2:0] bit_pos;
  logic [1:0] byte_pos;
  logic [7:0] shifter;
  logic [7:0] held_byte;
  logic       data_write;
  logic [7:0] polls;
  logic       nack;
  logic       scl;
  logic       sda;

  function new();
    mismatches = 0;
    addr_byte = DEVICE_ADDRESS_RESET;
    timeout_ticks = ACK_TIMEOUT_RESET;
    phase = PH_IDLE;
    bit_pos = '0;
    byte_pos = '0;
    shifter = '0;
    held_byte = '0;
    data_write = 1'b0;
    polls = '0;
    nack = 1'b0;
    scl = 1'b1;
    sda = 1'b1;
  endfunction

  function void set_regs(input logic [7:0] addr, input logic [7:0] ticks);
    addr_byte = addr;
    timeout_ticks = ticks;
  endfunction

  function bit bus_busy();
    return phase != PH_IDLE;
  endfunction

  function int pending();
    return expected_levels.size();
  endfunction

  // The acknowledge slot is over: pull SCL low and move on to the next byte
  // or to the stop condition.
  function void end_byte();
    scl = 1'b0;
    byte_pos = byte_pos + 2'd1;
    bit_pos = '0;
    if (byte_pos >= 2'(BYTES_PER_WRITE)) begin
      phase = PH_STOP_SDA;
    end else begin
      if (byte_pos == 2'd1) begin
        shifter = data_write ? CTRL_DATA : CTRL_CMD;
      end else begin
        shifter = held_byte;
      end
      phase = PH_BIT_SET;
    end
  endfunction

  function void note_tick(input item_t it);
    result_t    want;
    logic       done;
    logic [7:0] limit;
    done = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (it.command == CMD_WRITE || it.command == CMD_DATA) begin
          held_byte = it.payload;
          data_write = (it.command == CMD_DATA);
          nack = 1'b0;
          byte_pos = '0;
          bit_pos = '0;
          polls = '0;
          shifter = addr_byte;
          scl = 1'b1;
          sda = 1'b1;
          phase = PH_START_SDA;
        end
      end
      PH_START_SDA: begin
        scl = 1'b1;
        sda = 1'b0;
        phase = PH_START_SCL;
      end
      PH_START_SCL: begin
        scl = 1'b0;
        sda = 1'b0;
        phase = PH_BIT_SET;
      end
      PH_BIT_SET: begin
        scl = 1'b0;
        sda = shifter[7];
        shifter = {shifter[6:0], 1'b0};
        phase = PH_BIT_HIGH;
      end
      PH_BIT_HIGH: begin
        scl = 1'b1;
        phase = PH_BIT_LOW;
      end
      PH_BIT_LOW: begin
        scl = 1'b0;
        if (bit_pos >= 3'(BITS_PER_BYTE - 1)) begin
          bit_pos = '0;
          phase = PH_ACK_REL;
        end else begin
          bit_pos = bit_pos + 3'd1;
          phase = PH_BIT_SET;
        end
      end
      PH_ACK_REL: begin
        scl = 1'b0;
        sda = 1'b1;
        polls = '0;
        phase = PH_ACK_CLK;
      end
      PH_ACK_CLK: begin
        scl = 1'b1;
        sda = 1'b1;
        phase = PH_ACK_POLL;
      end
      PH_ACK_POLL: begin
        if (!it.sda_in) begin
          end_byte();
        end else begin
          limit = (timeout_ticks == 8'd0) ? 8'd1 : timeout_ticks;
          polls = polls + 8'd1;
          if (polls >= limit || polls == 8'd0) begin
            nack = 1'b1;
            end_byte();
          end
        end
      end
      PH_STOP_SDA: begin
        scl = 1'b0;
        sda = 1'b0;
        phase = PH_STOP_SCL;
      end
      PH_STOP_SCL: begin
        scl = 1'b1;
        sda = 1'b0;
        phase = PH_STOP_END;
      end
      PH_STOP_END: begin
        scl = 1'b1;
        sda = 1'b1;
        done = 1'b1;
        phase = PH_IDLE;
      end
      default: begin
        phase = PH_IDLE;
      end
    endcase
    want.scl_level = scl;
    want.sda_level = sda;
    want.busy_res = (phase != PH_IDLE);
    want.done_res = done;
    want.nack_seen = nack;
    expected_levels.push_back(want);
  endfunction

  function void check_levels(input result_t got);
    result_t want;
    logic    bad;
    if (expected_levels.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected result %b with nothing pending", got);
      end
      return;
    end
    want = expected_levels.pop_front();
    bad = (got.scl_level !== want.scl_level) || (got.sda_level !== want.sda_level) ||
          (got.busy_res !== want.busy_res) || (got.done_res !== want.done_res) ||
          (got.nack_seen !== want.nack_seen);
    if (bad) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: expected scl=%b sda=%b busy=%b done=%b nack=%b",
                 want.scl_level, want.sda_level, want.busy_res, want.done_res,
                 want.nack_seen);
        $display("          got      scl=%b sda=%b busy=%b done=%b nack=%b",
                 got.scl_level, got.sda_level, got.busy_res, got.done_res,
                 got.nack_seen);
      end
    end
  endfunction
endclass

module tb_top;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int TOTAL_TICKS = 1550;
  localparam int LONG_HOLD = 300;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum {ACK_ALWAYS, ACK_NEVER, ACK_RARE, ACK_COIN} ack_mode_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;
  logic    wr_en;
  logic    wr_index;
  logic [7:0] wr_data;

  i2c_line_scoreboard sb;
  int send_calm = 0;
  int take_calm = 0;
  int ticks_sent = 0;
  int cycle_count = 0;

  i2c_display_byte_writer_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** i2c_display_byte_writer_core: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      sb.check_levels(result);
    end
  end

  // Mostly short random waits, with occasional runs of back-to-back beats.
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(20, 60);
    end
    return $urandom_range(0, 5);
  endfunction

  function automatic logic ack_level(input ack_mode_t mode);
    case (mode)
      ACK_ALWAYS: return 1'b0;
      ACK_NEVER:  return 1'b1;
      ACK_RARE:   return ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
      default:    return 1'($urandom_range(0, 1));
    endcase
  endfunction

  task automatic send_tick(input logic [1:0] cmd, input logic [7:0] pay, input logic sda);
    int    gap;
    item_t it;
    it.command = cmd;
    it.payload = pay;
    it.sda_in = sda;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    sb.note_tick(it);
    ticks_sent++;
  endtask

  task automatic run_write(input logic [1:0] start_cmd, input logic [7:0] pay,
                           input ack_mode_t mode);
    logic [1:0] cmd;
    send_tick(start_cmd, pay, ack_level(mode));
    while (sb.bus_busy()) begin
      cmd = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(1, 3)) : CMD_TICK;
      send_tick(cmd, 8'($urandom), ack_level(mode));
    end
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] addr, input logic [7:0] ticks);
    wr_en <= 1'b1;
    wr_index <= REG_DEVICE_ADDRESS;
    wr_data <= addr;
    @(posedge clk);
    wr_index <= REG_ACK_TIMEOUT;
    wr_data <= ticks;
    @(posedge clk);
    wr_en <= 1'b0;
    sb.set_regs(addr, ticks);
  endtask

  initial begin
    int wait_n;
    int taken;
    int hold_at;
    taken = 0;
    hold_at = $urandom_range(40, 70);
    result_stall <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      wait_n = (taken == hold_at) ? LONG_HOLD : draw_gap(take_calm);
      if (wait_n > 0) begin
        result_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid || result_stall);
      taken++;
    end
  end

  initial begin
    logic [7:0] addr_pick;
    logic [7:0] ticks_pick;
    logic [1:0] start_cmd;
    sb = new();
    item_valid <= 1'b0;
    item <= '0;
    wr_en <= 1'b0;
    wr_index <= REG_DEVICE_ADDRESS;
    wr_data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Idle ticks, including the unused command code, then writes at the
    // reset settings with commands thrown in while busy.
    send_tick(CMD_TICK, 8'h00, 1'b0);
    send_tick(CMD_TICK, 8'hFF, 1'b1);
    send_tick(CMD_UNUSED, 8'hA5, 1'b1);
    run_write(CMD_WRITE, 8'hFF, ACK_ALWAYS);
    run_write(CMD_DATA, 8'h00, ACK_COIN);

    // A missed acknowledge must stick after the write and clear on the next.
    settle();
    set_config(8'h00, 8'd1);
    run_write(CMD_DATA, 8'h5A, ACK_NEVER);
    send_tick(CMD_TICK, 8'h00, 1'b1);
    send_tick(CMD_UNUSED, 8'hFF, 1'b0);
    run_write(CMD_WRITE, 8'h81, ACK_ALWAYS);

    settle();
    set_config(8'hFF, 8'd0);
    run_write(CMD_WRITE, 8'h3C, ACK_NEVER);

    settle();
    set_config(8'hA5, 8'd255);
    run_write(CMD_DATA, 8'hC3, ACK_NEVER);

    while (ticks_sent < TOTAL_TICKS) begin
      if ($urandom_range(0, 5) == 0) begin
        settle();
        case ($urandom_range(0, 2))
          0:       addr_pick = 8'h00;
          1:       addr_pick = 8'hFF;
          default: addr_pick = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 9))
          0:       ticks_pick = 8'd0;
          1:       ticks_pick = 8'd1;
          2:       ticks_pick = 8'd255;
          3:       ticks_pick = ACK_TIMEOUT_RESET;
          default: ticks_pick = 8'($urandom_range(1, 8));
        endcase
        set_config(addr_pick, ticks_pick);
      end
      repeat ($urandom_range(0, 3)) begin
        send_tick($urandom_range(0, 1) ? CMD_TICK : CMD_UNUSED, 8'($urandom),
                  1'($urandom_range(0, 1)));
      end
      start_cmd = $urandom_range(0, 1) ? CMD_WRITE : CMD_DATA;
      run_write(start_cmd, 8'($urandom), ack_mode_t'($urandom_range(0, 3)));
    end

    settle();
    if (sb.mismatches == 0) begin
      $display("** i2c_display_byte_writer_core: PASSED **");
    end else begin
      $display("** i2c_display_byte_writer_core: FAILED **");
    end
    $finish;
  end

endmodule
